FILE: src/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants of the single-precision portable word codec.
// ----------------------------------------------------------------------------
package fpc_pkg;

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    localparam logic [7:0] EXP_ALL_ONES = 8'hff;
    localparam logic [9:0] EXP_BIAS     = 10'd127;

    // Classified operand, after stage two
    typedef struct packed {
        logic              valid;
        logic              action;
        logic              sign;
        logic              zero;
        logic              inf_nan;
        logic              subn;
        logic [23:0]       mag;
        logic [4:0]        lead;
        logic signed [9:0] exp;
    } cls_t;

    // Aligned operand, after stage three
    typedef struct packed {
        logic              valid;
        logic              action;
        logic              sign;
        logic              zero;
        logic              inf_nan;
        logic signed [9:0] exp;
        logic [30:0]       body;
    } aln_t;

endpackage

FILE: src/fpc_classify.sv
// ----------------------------------------------------------------------------
// fpc_classify
// Splits the operand into sign, exponent and magnitude, finds the leading one.
// ----------------------------------------------------------------------------
module fpc_classify (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          action,
    input  logic [31:0]   word,
    output fpc_pkg::cls_t cls
);
    import fpc_pkg::*;

    cls_t cls_reg;
    cls_t cls_next;

    always_comb
    begin
        logic [7:0]  ee;
        logic [22:0] frac;
        logic [23:0] u;
        logic [6:0]  eh;
        ee   = word[30:23];
        frac = word[22:0];
        u    = word[31:8];
        eh   = word[7:1];
        cls_next        = '0;
        cls_next.valid  = in_valid;
        cls_next.action = action;
        if (action == ACT_ENCODE)
        begin
            cls_next.sign    = word[31];
            cls_next.inf_nan = (ee == EXP_ALL_ONES);
            cls_next.subn    = (ee == 8'd0);
            cls_next.zero    = (ee == 8'd0) && (frac == 23'd0);
            cls_next.mag     = {(ee != 8'd0), frac};
            cls_next.exp     = $signed({2'b00, ee} - EXP_BIAS);
        end
        else
        begin
            // odd zigzag codes are negative: magnitude is half plus one
            cls_next.sign = u[0];
            cls_next.mag  = {1'b0, u[23:1]} + {23'd0, u[0]};
            cls_next.zero = (cls_next.mag == 24'd0);
            if (word[0])
                cls_next.exp = -$signed({3'b000, eh});
            else
                cls_next.exp = $signed({3'b000, eh}) + 10'sd1;
        end
        for (int i = 0; i < 24; i++)
        begin
            if (cls_next.mag[i])
                cls_next.lead = 5'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cls_reg <= '0;
        else
            cls_reg <= cls_next;
    end

    assign cls = cls_reg;

endmodule

FILE: src/fpc_align.sv
// ----------------------------------------------------------------------------
// fpc_align
// Normalizes the significand; on decode, builds exponent and fraction fields.
// ----------------------------------------------------------------------------
module fpc_align (
    input  logic          clk,
    input  logic          rst_n,
    input  fpc_pkg::cls_t cls,
    output fpc_pkg::aln_t aln
);
    import fpc_pkg::*;

    aln_t aln_reg;
    aln_t aln_next;

    always_comb
    begin
        logic [23:0]       norm;
        logic signed [9:0] e_unb;
        logic signed [9:0] sh;
        logic [7:0]        biased;
        logic [22:0]       frac;
        norm   = cls.mag << (5'd23 - cls.lead);
        e_unb  = $signed({5'd0, cls.lead}) + cls.exp - 10'sd23;
        sh     = cls.exp + 10'sd126;
        biased = 8'd0;
        frac   = 23'd0;
        aln_next         = '0;
        aln_next.valid   = cls.valid;
        aln_next.action  = cls.action;
        aln_next.sign    = cls.sign;
        aln_next.zero    = cls.zero;
        aln_next.inf_nan = cls.inf_nan;
        if (cls.action == ACT_ENCODE)
        begin
            if (cls.subn)
            begin
                aln_next.exp  = $signed({5'd0, cls.lead}) - 10'sd149;
                aln_next.body = {8'd0, norm[23:1]};
            end
            else
            begin
                aln_next.exp  = cls.exp;
                aln_next.body = {8'd0, cls.mag[23:1]};
            end
        end
        else
        begin
            if (e_unb > 10'sd127)
            begin
                biased = EXP_ALL_ONES;
            end
            else if (e_unb >= -10'sd126)
            begin
                biased = 8'(e_unb + $signed(EXP_BIAS));
                frac   = norm[22:0];
            end
            else if (sh < 10'sd0)
            begin
                // halve with round to nearest even
                frac = cls.mag[23:1] + {22'd0, cls.mag[0] & cls.mag[1]};
            end
            else
            begin
                frac = 23'(cls.mag << sh[4:0]);
            end
            aln_next.body = {biased, frac};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            aln_reg <= '0;
        else
            aln_reg <= aln_next;
    end

    assign aln = aln_reg;

endmodule

FILE: src/fpc_pack.sv
// ----------------------------------------------------------------------------
// fpc_pack
// Zigzags exponent and significand on encode, assembles the result word.
// ----------------------------------------------------------------------------
module fpc_pack (
    input  logic          clk,
    input  logic          rst_n,
    input  fpc_pkg::aln_t aln,
    output logic          done,
    output logic [31:0]   result_word,
    output logic          not_finite
);
    import fpc_pkg::*;

    logic        done_reg;
    logic [31:0] result_reg;
    logic [31:0] result_next;
    logic        nf_reg;
    logic        nf_next;

    always_comb
    begin
        logic [9:0]  zexp;
        logic [23:0] zsig;
        logic [9:0]  neg_exp;
        neg_exp = 10'(-aln.exp);
        if (aln.exp >= 10'sd0)
            zexp = {aln.exp[8:0], 1'b0};
        else
            zexp = {neg_exp[8:0], 1'b0} - 10'd1;
        zsig = {aln.body[22:0], 1'b0} - {23'd0, aln.sign};
        nf_next = 1'b0;
        if (aln.action == ACT_ENCODE)
        begin
            if (aln.inf_nan)
            begin
                result_next = 32'd0;
                nf_next     = 1'b1;
            end
            else if (aln.zero)
                result_next = 32'd1;
            else
                result_next = {zsig, 8'd0} | {22'd0, zexp};
        end
        else
        begin
            if (aln.zero)
                result_next = 32'd0;
            else
                result_next = {aln.sign, aln.body};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= aln.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        nf_reg     <= nf_next;
    end

    assign done        = done_reg;
    assign result_word = result_reg;
    assign not_finite  = nf_reg;

endmodule

FILE: src/float32_portable_word_codec_unit.sv
// ----------------------------------------------------------------------------
// float32_portable_word_codec_unit
// Single-precision word to portable code converter and back.
// ----------------------------------------------------------------------------
// Usage:
//   Drive action and operand_word with start high; a beat is taken at each
//   rising edge where start is high and busy is low. busy is always low, so
//   a new beat may be issued every cycle.
//   action low encodes IEEE single bits into the portable code; action high
//   decodes a code back to single bits.
//   Each beat yields one result: done is high for one cycle with result_word
//   and not_finite, from the pack register after the input, classify and
//   align registers. Results leave in issue order. Throughput is one beat
//   per cycle; the four register stages are input, classify, align, pack.
//   not_finite flags an infinity or NaN on encode; result_word is then zero.
//   The receiver cannot stall: it must take done when it appears.
//   Reset clears all valid bits; beats in flight are dropped.
// ----------------------------------------------------------------------------
module float32_portable_word_codec_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] operand_word,
    output logic        done,
    output logic [31:0] result_word,
    output logic        not_finite
);
    import fpc_pkg::*;

    logic        in_valid_reg;
    logic        in_action_reg;
    logic [31:0] in_word_reg;
    cls_t        cls;
    aln_t        aln;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_action_reg <= action;
        in_word_reg   <= operand_word;
    end

    fpc_classify u_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .action   (in_action_reg),
        .word     (in_word_reg),
        .cls      (cls)
    );

    fpc_align u_align (
        .clk   (clk),
        .rst_n (rst_n),
        .cls   (cls),
        .aln   (aln)
    );

    fpc_pack u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .aln         (aln),
        .done        (done),
        .result_word (result_word),
        .not_finite  (not_finite)
    );

endmodule
